[rtl/lpht_pkg.sv]
`default_nettype none

package lpht_pkg;

   // Table geometry
   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);

   // Word field widths
   localparam int KEY_W      = 64;
   localparam int PHONE_W    = 48;
   localparam int STATUS_W   = 3;
   localparam int RSP_SLOT_W = 4;

   // Hash: sum of eight key bytes, then reduced modulo the slot count
   localparam int KEY_BYTES = KEY_W / 8;
   localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);

   // Request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_MISSING   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } state_type;

   // Store write command from the sequencer
   typedef struct packed {
      logic               we;
      logic [SLOT_W-1:0]  addr;
      logic [KEY_W-1:0]   key;
      logic [PHONE_W-1:0] phone;
   } wr_cmd_type;

endpackage

`default_nettype wire

[rtl/linear_probe_hash_table_top.sv]
`default_nettype none

// Hash table with linear probing: maps a 64-bit name key to a 48-bit phone.
// Request: drive req_type (0 insert, 1 search), req_key and req_phone with
// start high; the word is taken at a clock edge where start is high and busy
// is low. busy stays high until the request is answered.
// Response: one word per request on rsp_status, rsp_phone_out and rsp_slot,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// Flow: an insert into a full table is answered straight from the idle state.
// Every other request passes through the hash unit (byte sum folded onto the
// table), then probes slots in turn, up to TABLE_SLOTS probes, and is answered
// by a registered response after the last probe.
// The probe loop reads one slot a cycle from the key/phone memory port.
// A new request may be taken in the cycle its predecessor's response shows.
// Reset (synchronous, active high) clears the valid marks and the entry
// count at once; the table is empty and ready in the next cycle.
module linear_probe_hash_table_top
   import lpht_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_type,
   input  wire logic [KEY_W-1:0]      req_key,
   input  wire logic [PHONE_W-1:0]    req_phone,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [PHONE_W-1:0]         rsp_phone_out,
   output logic [RSP_SLOT_W-1:0]      rsp_slot
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

   state_type          state_ff, state_in;
   logic               type_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [PHONE_W-1:0] phone_ff;
   logic [SLOT_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [PHONE_W-1:0] rsp_phone_ff, rsp_phone_in;
   logic [SLOT_W-1:0]  rsp_pos_ff, rsp_pos_in;

   logic               accept;
   logic               hash_go;
   logic               hash_done;
   logic [SLOT_W-1:0]  hash;
   wr_cmd_type         wr;
   logic [SLOT_W-1:0]  rd_addr;
   logic               chk_valid;
   logic [KEY_W-1:0]   rd_key;
   logic [PHONE_W-1:0] rd_phone;
   logic               full;
   logic [SLOT_W-1:0]  next_pos;
   logic               key_hit;
   logic               last_probe;
   logic               probe_end;
   logic               full_reply;

   lpht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .go    (hash_go),
      .key   (req_key),
      .done  (hash_done),
      .hash  (hash)
   );

   lpht_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .rd_addr   (rd_addr),
      .chk_addr  (pos_ff),
      .chk_valid (chk_valid),
      .rd_key    (rd_key),
      .rd_phone  (rd_phone),
      .full      (full)
   );

   // Probe decode
   assign accept     = start && !busy;
   assign full_reply = accept && (req_type == REQ_INSERT) && full;
   assign next_pos   = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign key_hit    = chk_valid && (rd_key == key_ff);
   assign last_probe = (cnt_ff == LAST_SLOT);
   assign probe_end  = (state_ff == ST_PROBE) && (!chk_valid || key_hit || last_probe);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !full_reply) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      hash_go      = 1'b0;
      rd_addr      = pos_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      wr.we        = 1'b0;
      wr.addr      = pos_ff;
      wr.key       = key_ff;
      wr.phone     = phone_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      rsp_phone_in = rsp_phone_ff;
      rsp_pos_in   = rsp_pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (full_reply) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_FULL;
               rsp_phone_in = '0;
               rsp_pos_in   = '0;
            end else if (accept) begin
               hash_go = 1'b1;
            end
         end
         ST_HASH: begin
            // Start the first read at the hash slot
            rd_addr = hash;
            pos_in  = hash;
            cnt_in  = '0;
         end
         ST_PROBE: begin
            rd_addr = next_pos;
            if (probe_end) begin
               rsp_valid_in = 1'b1;
               rsp_phone_in = '0;
               rsp_pos_in   = '0;
               if (type_ff == REQ_INSERT) begin
                  if (!chk_valid) begin
                     wr.we      = 1'b1;
                     status_in  = STAT_INSERTED;
                     rsp_pos_in = pos_ff;
                  end else if (key_hit) begin
                     status_in = STAT_DUPLICATE;
                  end else begin
                     status_in = STAT_FULL;
                  end
               end else begin
                  if (key_hit) begin
                     status_in    = STAT_FOUND;
                     rsp_phone_in = rd_phone;
                     rsp_pos_in   = pos_ff;
                  end else begin
                     status_in = STAT_MISSING;
                  end
               end
            end else begin
               // Advance to the next slot
               pos_in = next_pos;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            rd_addr = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture and datapath, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         key_ff   <= req_key;
         phone_ff <= req_phone;
      end
      pos_ff       <= pos_in;
      cnt_ff       <= cnt_in;
      status_ff    <= status_in;
      rsp_phone_ff <= rsp_phone_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_phone_out = rsp_phone_ff;
   assign rsp_slot      = RSP_SLOT_W'(rsp_pos_ff);

   // A response follows either a probe outcome or an insert into a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_PROBE || (start && !busy)))
      else $error("response without a finished request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (state_ff == ST_PROBE) && (type_ff == REQ_INSERT))
      else $error("store write outside an insert probe");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HASH) && hash_done |=> (state_ff == ST_PROBE) && (cnt_ff == '0))
      else $error("probe did not start at the hash slot");

endmodule

`default_nettype wire

[rtl/lpht_hash.sv]
`default_nettype none

module lpht_hash
   import lpht_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [KEY_W-1:0]  key,
   output logic                   done,
   output logic [SLOT_W-1:0]      hash
);

   logic [SUM_W-1:0]  byte_sum;
   logic [SLOT_W-1:0] hash_ff, hash_in;
   logic              done_ff, done_in;

   // Add the key bytes
   always_comb begin
      byte_sum = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         byte_sum = byte_sum + SUM_W'(key[8*b +: 8]);
      end
   end

   // Fold the byte sum onto the table when a request starts
   always_comb begin
      hash_in = hash_ff;
      done_in = go;
      if (go) begin
         hash_in = SLOT_W'(byte_sum % SUM_W'(TABLE_SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   // Hold the home slot, no reset
   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign done = done_ff;
   assign hash = hash_ff;

endmodule

`default_nettype wire

[rtl/lpht_store.sv]
`default_nettype none

module lpht_store
   import lpht_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wr_cmd_type          wr,
   input  wire logic [SLOT_W-1:0]   rd_addr,
   input  wire logic [SLOT_W-1:0]   chk_addr,
   output logic                     chk_valid,
   output logic [KEY_W-1:0]         rd_key,
   output logic [PHONE_W-1:0]       rd_phone,
   output logic                     full
);

   logic [KEY_W-1:0]   key_mem   [TABLE_SLOTS];
   logic [PHONE_W-1:0] phone_mem [TABLE_SLOTS];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [PHONE_W-1:0] rd_phone_ff;
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [COUNT_W-1:0]     count_ff;

   // Key and phone memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         key_mem[wr.addr]   <= wr.key;
         phone_mem[wr.addr] <= wr.phone;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_phone_ff <= phone_mem[rd_addr];
   end

   // Valid marks and entry count, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.addr] <= 1'b1;
         count_ff          <= count_ff + 1'b1;
      end
   end

   assign chk_valid = valid_ff[chk_addr];
   assign rd_key    = rd_key_ff;
   assign rd_phone  = rd_phone_ff;
   assign full      = (count_ff == COUNT_W'(TABLE_SLOTS));

   // Never write over a live entry, never pass the slot count
   assert property (@(posedge clock) disable iff (reset)
      wr.we |-> !valid_ff[wr.addr])
      else $error("write to an occupied slot");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_SLOTS))
      else $error("entry count above slot count");

   assert property (@(posedge clock) disable iff (reset)
      wr.we |=> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count missed a write");

endmodule

`default_nettype wire

[sim/tb_linear_probe_hash_table_top.sv]
module tb_linear_probe_hash_table_top import lpht_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // One answer word as the block should present it
   typedef struct {
      status_type                status;
      logic [PHONE_W-1:0]        phone;
      logic [RSP_SLOT_W-1:0]     slot;
   } answer_type;

   // Own copy of the table; predicts the answer to each accepted request
   class directory_tracker;
      bit                  used[TABLE_SLOTS];
      logic [KEY_W-1:0]    keys[TABLE_SLOTS];
      logic [PHONE_W-1:0]  phones[TABLE_SLOTS];
      int unsigned         entries;
      answer_type          awaited_answers[$];
      int unsigned         errors;

      function new();
         entries = 0;
         errors  = 0;
         foreach (used[i]) used[i] = 1'b0;
      endfunction

      // Byte sum of the key, folded onto the table
      static function int unsigned key_hash(logic [KEY_W-1:0] k);
         int unsigned total;
         total = 0;
         for (int b = 0; b < KEY_W / 8; b++) total += k[8*b +: 8];
         return total % TABLE_SLOTS;
      endfunction

      function int unsigned pending();
         return awaited_answers.size();
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
         errors++;
      endtask

      // Update the table for an accepted word and queue its answer
      function status_type note_request(logic kind, logic [KEY_W-1:0] k,
                                        logic [PHONE_W-1:0] ph);
         int unsigned pos;
         answer_type  ans;
         pos        = key_hash(k);
         ans.status = STAT_MISSING;
         ans.phone  = '0;
         ans.slot   = '0;
         if (kind == REQ_INSERT) begin
            ans.status = STAT_FULL;
            if (entries < TABLE_SLOTS) begin
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (!used[pos]) begin
                     used[pos]   = 1'b1;
                     keys[pos]   = k;
                     phones[pos] = ph;
                     entries++;
                     ans.status  = STAT_INSERTED;
                     ans.slot    = RSP_SLOT_W'(pos);
                     break;
                  end
                  if (keys[pos] == k) begin
                     ans.status = STAT_DUPLICATE;
                     break;
                  end
                  pos = (pos + 1) % TABLE_SLOTS;
               end
            end
         end else begin
            // Stop at an empty slot, at a matching key or after one full lap
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!used[pos]) break;
               if (keys[pos] == k) begin
                  ans.status = STAT_FOUND;
                  ans.phone  = phones[pos];
                  ans.slot   = RSP_SLOT_W'(pos);
                  break;
               end
               pos = (pos + 1) % TABLE_SLOTS;
            end
         end
         awaited_answers.push_back(ans);
         return ans.status;
      endfunction

      // Compare an answer word against the oldest one awaited
      task check_response(logic [STATUS_W-1:0] status, logic [PHONE_W-1:0] phone,
                          logic [RSP_SLOT_W-1:0] slot);
         answer_type ans;
         if (awaited_answers.size() == 0) begin
            report("answer with no request pending, status", status, 0);
         end else begin
            ans = awaited_answers.pop_front();
            if (status !== ans.status) report("status", status, ans.status);
            if (phone !== ans.phone) report("phone_out", phone, ans.phone);
            if (slot !== ans.slot) report("slot", slot, ans.slot);
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   req_type = REQ_INSERT;
   logic [KEY_W-1:0]       req_key = '0;
   logic [PHONE_W-1:0]     req_phone = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [PHONE_W-1:0]     rsp_phone_out;
   logic [RSP_SLOT_W-1:0]  rsp_slot;

   directory_tracker       book;
   logic [KEY_W-1:0]       known_keys[$];
   int unsigned            burst_left = 0;

   linear_probe_hash_table_top u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_key       (req_key),
      .req_phone     (req_phone),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_phone_out (rsp_phone_out),
      .rsp_slot      (rsp_slot)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [PHONE_W-1:0] rand_phone();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[PHONE_W-1:0];
   endfunction

   // Bend the low byte so the key lands on a chosen home slot
   function automatic logic [KEY_W-1:0] key_with_hash(logic [KEY_W-1:0] raw,
                                                      int unsigned h);
      logic [KEY_W-1:0] k;
      int unsigned      now;
      k       = raw;
      now     = directory_tracker::key_hash(raw);
      k[7:0]  = raw[7:0] + 8'((h + TABLE_SLOTS - now) % TABLE_SLOTS);
      return k;
   endfunction

   // Present one word, hold it until taken, then log it
   task automatic issue_request(logic kind, logic [KEY_W-1:0] k, logic [PHONE_W-1:0] ph);
      start     <= 1'b1;
      req_type  <= kind;
      req_key   <= k;
      req_phone <= ph;
      do @(posedge clock); while (busy);
      if (book.note_request(kind, k, ph) == STAT_INSERTED) known_keys.push_back(k);
   endtask

   // Insert idle gaps between bursts of back-to-back words
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start     <= 1'b0;
            req_type  <= 1'($urandom);
            req_key   <= rand_key();
            req_phone <= rand_phone();
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Hold off until every awaited answer is back
   task automatic drain_answers();
      start <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // Check every answer word the block shows
   always @(posedge clock) begin
      if (!reset && rsp_valid) book.check_response(rsp_status, rsp_phone_out, rsp_slot);
   end

   initial begin
      logic [KEY_W-1:0]   k;
      logic [KEY_W-1:0]   key_a;
      logic [KEY_W-1:0]   key_b;
      logic [KEY_W-1:0]   key_c;
      logic [PHONE_W-1:0] ph;
      logic               kind;
      int unsigned        roll;
      int unsigned        pick;
      int unsigned        p_new;
      bit                 full;

      book = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, wrap-around and collisions
      key_a = key_with_hash(rand_key(), TABLE_SLOTS - 1);
      key_b = key_with_hash(rand_key(), TABLE_SLOTS - 1);
      key_c = key_with_hash(rand_key(), TABLE_SLOTS - 1);
      issue_request(REQ_SEARCH, '0, rand_phone());
      issue_request(REQ_INSERT, '0, '0);
      issue_request(REQ_INSERT, '1, '1);
      issue_request(REQ_SEARCH, '1, '0);
      issue_request(REQ_SEARCH, '0, '1);
      issue_request(REQ_INSERT, '0, rand_phone());
      issue_request(REQ_INSERT, key_a, rand_phone());
      issue_request(REQ_INSERT, key_b, rand_phone());
      issue_request(REQ_SEARCH, key_b, rand_phone());
      issue_request(REQ_SEARCH, key_c, rand_phone());
      issue_request(REQ_INSERT, key_with_hash(rand_key(), TABLE_SLOTS / 2), rand_phone());
      issue_request(REQ_INSERT, key_b, rand_phone());
      issue_request(REQ_SEARCH, {1'b0, {(KEY_W-1){1'b1}}}, '1);
      issue_request(REQ_SEARCH, key_a ^ 64'd1, '0);
      drain_answers();

      // Random: slow fill with mostly hits and duplicates, then a full table
      for (int n = 0; n < 1450; n++) begin
         pace_sender();
         if (n % 300 == 150) drain_answers();
         full  = known_keys.size() >= TABLE_SLOTS;
         ph    = rand_phone();
         roll  = $urandom_range(0, 99);
         p_new = (n < 1000) ? 3 : 25;
         if (!full && (roll < p_new || n >= 1100)) begin
            kind = REQ_INSERT;
            if ($urandom_range(0, 1) == 1)
               k = key_with_hash(rand_key(), (TABLE_SLOTS - 1 + $urandom_range(0, 2)) % TABLE_SLOTS);
            else
               k = rand_key();
         end else begin
            pick = $urandom_range(0, 99);
            if (known_keys.size() != 0)
               k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
               k = rand_key();
            if (pick < 25) begin
               kind = REQ_INSERT;
            end else if (pick < 60) begin
               kind = REQ_SEARCH;
            end else if (pick < 75) begin
               kind = REQ_SEARCH;
               k    = k ^ (64'd1 << $urandom_range(0, KEY_W - 1));
            end else begin
               kind = full ? 1'($urandom) : REQ_SEARCH;
               k    = rand_key();
            end
         end
         issue_request(kind, k, ph);
      end

      // Let the last answers come in, then judge
      start <= 1'b0;
      for (int w = 0; w < 5000 && book.pending() != 0; w++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (book.pending() != 0) book.report("answers never arrived, count", book.pending(), 0);
      if (book.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Stop a hung run
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
